@@ hw/rtl/rotated_block_move_row_sequencer_unit_assert.svh @@
// Assertion macros shared by the row sequencer RTL.
// In synthesis builds the macros expand to nothing.
`ifndef ROTATED_BLOCK_MOVE_ROW_SEQUENCER_UNIT_ASSERT_SVH
`define ROTATED_BLOCK_MOVE_ROW_SEQUENCER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// The expression holds at every clock edge outside of reset.
`define RBMRS_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("rbmrs assertion failed");

// The consequent holds in the cycle after the antecedent.
`define RBMRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rbmrs assertion failed");

`else

`define RBMRS_ASSERT_ALWAYS(label, clk, rst, expr)
`define RBMRS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hw/rtl/rbmrs_pkg.sv @@
`default_nettype none

package rbmrs_pkg;

   localparam int MAX_RES     = 4096;
   localparam int OFFSET_BITS = 24;
   localparam int COORD_BITS  = 12;
   localparam int SHIFT_BITS  = 13;
   localparam int LEN_BITS    = 13;
   localparam int CALC_BITS   = 16;
   localparam int CSR_BITS    = 2;

   localparam logic OP_START = 1'b0;
   localparam logic OP_NEXT  = 1'b1;

   localparam logic [CSR_BITS-1:0] CSR_ROTATE_CLOCKWISE = 2'd0;
   localparam logic [CSR_BITS-1:0] CSR_CANVAS_WIDTH     = 2'd1;
   localparam logic [CSR_BITS-1:0] CSR_CANVAS_HEIGHT    = 2'd2;
   localparam logic [CSR_BITS-1:0] CSR_ROW_PITCH        = 2'd3;

   // Geometry of one transaction, prepared in the accept cycle.
   typedef struct packed {
      logic                          opcode;
      logic                          empty;
      logic                          walk_upward;
      logic signed [CALC_BITS-1:0]   dest_row;
      logic signed [CALC_BITS-1:0]   source_row;
      logic [OFFSET_BITS-1:0]        dest_col;
      logic [OFFSET_BITS-1:0]        source_col;
      logic [OFFSET_BITS-1:0]        dest_col_next;
      logic [OFFSET_BITS-1:0]        source_col_next;
      logic [LEN_BITS-1:0]           copy_length;
      logic [LEN_BITS-1:0]           row_count;
   } plan_type;

endpackage

`default_nettype wire

@@ hw/rtl/rotated_block_move_row_sequencer_unit.sv @@
// Row command sequencer for block moves on a rotated 16-bit frame buffer. Every
// transaction on the req channel gives exactly one transaction on the rsp channel:
// a start maps the rectangle into the rotated frame, picks an overlap-safe copy order
// and returns the first row, and each next returns the following row (or an empty
// result with last_row set once the move is done). The unit accepts one transaction
// per cycle while req_stall is low and presents its result on the rsp ports from
// the result register: the rotated geometry is computed in the accept cycle into an
// input register, and the row offsets (one 16x14 multiplier for each of destination
// and source) are computed from that register into the result register, which also
// updates the move state so that the next transaction sees it. A stalled result
// holds the input register, and req_stall rises only while both registers are full.
// Offsets wrap modulo 2^24. Configuration must only be written while idle.
`default_nettype none

module rotated_block_move_row_sequencer_unit (
   input  wire logic                                    clock,
   input  wire logic                                    reset,

   input  wire logic                                    csr_write,
   input  wire logic [rbmrs_pkg::CSR_BITS-1:0]          csr_index,
   input  wire logic [rbmrs_pkg::LEN_BITS-1:0]          csr_data,

   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic                                    req_opcode,
   input  wire logic [rbmrs_pkg::COORD_BITS-1:0]        req_rect_left,
   input  wire logic [rbmrs_pkg::COORD_BITS-1:0]        req_rect_top,
   input  wire logic [rbmrs_pkg::COORD_BITS-1:0]        req_rect_right,
   input  wire logic [rbmrs_pkg::COORD_BITS-1:0]        req_rect_bottom,
   input  wire logic signed [rbmrs_pkg::SHIFT_BITS-1:0] req_shift_x,
   input  wire logic signed [rbmrs_pkg::SHIFT_BITS-1:0] req_shift_y,

   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic                                         rsp_row_valid,
   output logic [rbmrs_pkg::OFFSET_BITS-1:0]            rsp_dest_offset,
   output logic [rbmrs_pkg::OFFSET_BITS-1:0]            rsp_source_offset,
   output logic [rbmrs_pkg::LEN_BITS-1:0]               rsp_row_length,
   output logic                                         rsp_last_row
);

`include "rotated_block_move_row_sequencer_unit_assert.svh"

   localparam int OB = rbmrs_pkg::OFFSET_BITS;
   localparam int LB = rbmrs_pkg::LEN_BITS;
   localparam int CB = rbmrs_pkg::CALC_BITS;
   localparam int PB = CB + LB + 1;

   // Configuration registers.
   logic          rotate_clockwise_ff;
   logic [LB-1:0] canvas_width_ff, canvas_height_ff, row_pitch_ff;

   // Input stage.
   rbmrs_pkg::plan_type plan_in, plan_ff;
   logic                plan_valid_ff, plan_valid_in;

   // Move state.
   logic          busy_ff, busy_in;
   logic [LB-1:0] rows_left_ff, rows_left_in;
   logic [OB-1:0] dest_cursor_ff, dest_cursor_in, source_cursor_ff, source_cursor_in;
   logic [LB-1:0] copy_length_ff, copy_length_in;
   logic          walk_upward_ff, walk_upward_in;

   // Result register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_row_valid_ff, rsp_row_valid_in;
   logic [OB-1:0] rsp_dest_offset_ff, rsp_dest_offset_in;
   logic [OB-1:0] rsp_source_offset_ff, rsp_source_offset_in;
   logic [LB-1:0] rsp_row_length_ff, rsp_row_length_in;
   logic          rsp_last_row_ff, rsp_last_row_in;

   logic          out_free, advance, req_accept;
   logic signed [PB-1:0] dest_prod, source_prod;
   logic [OB-1:0] pitch_ext, dest_first, source_first, dest_first_next, source_first_next;
   logic [LB-1:0] rows_dec;

   rbmrs_geom u_geom (
      .opcode           (req_opcode),
      .rect_left        (req_rect_left),
      .rect_top         (req_rect_top),
      .rect_right       (req_rect_right),
      .rect_bottom      (req_rect_bottom),
      .shift_x          (req_shift_x),
      .shift_y          (req_shift_y),
      .rotate_clockwise (rotate_clockwise_ff),
      .canvas_width     (canvas_width_ff),
      .canvas_height    (canvas_height_ff),
      .row_pitch        (row_pitch_ff),
      .plan             (plan_in)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = plan_valid_ff && out_free;
   assign req_stall  = plan_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign plan_valid_in = req_accept || (plan_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);

   assign dest_prod   = $signed({{(PB - CB){plan_ff.dest_row[CB-1]}}, plan_ff.dest_row})
                      * $signed({{(PB - LB){1'b0}}, row_pitch_ff});
   assign source_prod = $signed({{(PB - CB){plan_ff.source_row[CB-1]}}, plan_ff.source_row})
                      * $signed({{(PB - LB){1'b0}}, row_pitch_ff});
   assign dest_first        = dest_prod[OB-1:0] + plan_ff.dest_col;
   assign source_first      = source_prod[OB-1:0] + plan_ff.source_col;
   assign dest_first_next   = dest_prod[OB-1:0] + plan_ff.dest_col_next;
   assign source_first_next = source_prod[OB-1:0] + plan_ff.source_col_next;
   assign pitch_ext = {{(OB - LB){1'b0}}, row_pitch_ff};

   always_comb begin
      busy_in = busy_ff;
      rows_left_in = rows_left_ff;
      dest_cursor_in = dest_cursor_ff;
      source_cursor_in = source_cursor_ff;
      copy_length_in = copy_length_ff;
      walk_upward_in = walk_upward_ff;
      rows_dec = rows_left_ff - LB'(1);

      // Default result carries no row.
      rsp_row_valid_in = 1'b0;
      rsp_dest_offset_in = '0;
      rsp_source_offset_in = '0;
      rsp_row_length_in = '0;
      rsp_last_row_in = 1'b1;

      if (plan_ff.opcode == rbmrs_pkg::OP_START) begin
         walk_upward_in = plan_ff.walk_upward;
         rows_dec = plan_ff.row_count - LB'(1);
         if (plan_ff.empty) begin
            busy_in = 1'b0;
            rows_left_in = '0;
         end else begin
            rsp_row_valid_in = 1'b1;
            rsp_dest_offset_in = dest_first;
            rsp_source_offset_in = source_first;
            rsp_row_length_in = plan_ff.copy_length;
            rsp_last_row_in = (rows_dec == '0);
            copy_length_in = plan_ff.copy_length;
            rows_left_in = rows_dec;
            busy_in = (rows_dec != '0);
            dest_cursor_in = dest_first_next;
            source_cursor_in = source_first_next;
         end
      end else if (busy_ff) begin
         rsp_row_valid_in = 1'b1;
         rsp_dest_offset_in = dest_cursor_ff;
         rsp_source_offset_in = source_cursor_ff;
         rsp_row_length_in = copy_length_ff;
         rsp_last_row_in = (rows_dec == '0);
         rows_left_in = rows_dec;
         busy_in = (rows_dec != '0);
         dest_cursor_in = walk_upward_ff ? dest_cursor_ff - pitch_ext
                                         : dest_cursor_ff + pitch_ext;
         source_cursor_in = walk_upward_ff ? source_cursor_ff - pitch_ext
                                           : source_cursor_ff + pitch_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rotate_clockwise_ff <= 1'b1;
         canvas_width_ff <= LB'(320);
         canvas_height_ff <= LB'(240);
         row_pitch_ff <= LB'(240);
      end else if (csr_write) begin
         case (csr_index)
            rbmrs_pkg::CSR_ROTATE_CLOCKWISE: rotate_clockwise_ff <= csr_data[0];
            rbmrs_pkg::CSR_CANVAS_WIDTH:     canvas_width_ff <= csr_data;
            rbmrs_pkg::CSR_CANVAS_HEIGHT:    canvas_height_ff <= csr_data;
            rbmrs_pkg::CSR_ROW_PITCH:        row_pitch_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plan_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         busy_ff <= 1'b0;
         rows_left_ff <= '0;
      end else begin
         plan_valid_ff <= plan_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            busy_ff <= busy_in;
            rows_left_ff <= rows_left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         plan_ff <= plan_in;
      end
      if (advance) begin
         dest_cursor_ff <= dest_cursor_in;
         source_cursor_ff <= source_cursor_in;
         copy_length_ff <= copy_length_in;
         walk_upward_ff <= walk_upward_in;
         rsp_row_valid_ff <= rsp_row_valid_in;
         rsp_dest_offset_ff <= rsp_dest_offset_in;
         rsp_source_offset_ff <= rsp_source_offset_in;
         rsp_row_length_ff <= rsp_row_length_in;
         rsp_last_row_ff <= rsp_last_row_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_row_valid = rsp_row_valid_ff;
   assign rsp_dest_offset = rsp_dest_offset_ff;
   assign rsp_source_offset = rsp_source_offset_ff;
   assign rsp_row_length = rsp_row_length_ff;
   assign rsp_last_row = rsp_last_row_ff;

   // A move is in progress exactly when rows remain to be issued.
   `RBMRS_ASSERT_ALWAYS(a_busy_rows, clock, reset, busy_ff == (rows_left_ff != '0))

   // The state always belongs to the transaction held in the result register.
   `RBMRS_ASSERT_ALWAYS(a_state_matches_rsp, clock, reset,
      !rsp_valid_ff || (busy_ff == (rsp_row_valid_ff && !rsp_last_row_ff)))

   // A result without a row carries zero fields and marks the end.
   `RBMRS_ASSERT_ALWAYS(a_empty_rsp, clock, reset,
      !rsp_valid_ff || rsp_row_valid_ff || (rsp_last_row_ff && rsp_row_length_ff == '0 &&
      rsp_dest_offset_ff == '0 && rsp_source_offset_ff == '0))

   // A transaction held in the input stage is not dropped while the output waits.
   `RBMRS_ASSERT_NEXT(a_plan_held, clock, reset, plan_valid_ff && !out_free, plan_valid_ff)

endmodule

`default_nettype wire

@@ hw/rtl/rbmrs_geom.sv @@
`default_nettype none

module rbmrs_geom (
   input  wire logic                                  opcode,
   input  wire logic [rbmrs_pkg::COORD_BITS-1:0]      rect_left,
   input  wire logic [rbmrs_pkg::COORD_BITS-1:0]      rect_top,
   input  wire logic [rbmrs_pkg::COORD_BITS-1:0]      rect_right,
   input  wire logic [rbmrs_pkg::COORD_BITS-1:0]      rect_bottom,
   input  wire logic signed [rbmrs_pkg::SHIFT_BITS-1:0] shift_x,
   input  wire logic signed [rbmrs_pkg::SHIFT_BITS-1:0] shift_y,
   input  wire logic                                  rotate_clockwise,
   input  wire logic [rbmrs_pkg::LEN_BITS-1:0]        canvas_width,
   input  wire logic [rbmrs_pkg::LEN_BITS-1:0]        canvas_height,
   input  wire logic [rbmrs_pkg::LEN_BITS-1:0]        row_pitch,
   output rbmrs_pkg::plan_type                        plan
);

   localparam int CB = rbmrs_pkg::CALC_BITS;
   localparam int OB = rbmrs_pkg::OFFSET_BITS;
   localparam int PAD_C = CB - rbmrs_pkg::COORD_BITS;
   localparam int PAD_S = CB - rbmrs_pkg::SHIFT_BITS;
   localparam int PAD_L = CB - rbmrs_pkg::LEN_BITS;
   localparam int PAD_O = OB - CB;
   localparam int PAD_P = OB - rbmrs_pkg::LEN_BITS;
   localparam logic signed [CB-1:0] ONE = CB'(1);
   localparam logic signed [CB-1:0] ZERO = CB'(0);
   localparam logic signed [CB-1:0] RES_LIMIT = CB'(rbmrs_pkg::MAX_RES);

   logic signed [CB-1:0] l, t, r, b, cw, ch, xs_raw, ys_raw;
   logic signed [CB-1:0] xs, ys, rl, rr, rt, rb, span_x, span_y;
   logic signed [CB-1:0] width, height, dest_col, source_col;
   logic [OB-1:0] pitch_ext, dest_col_ext, source_col_ext;
   logic walk_upward;

   always_comb begin
      l = $signed({{PAD_C{1'b0}}, rect_left});
      t = $signed({{PAD_C{1'b0}}, rect_top});
      r = $signed({{PAD_C{1'b0}}, rect_right});
      b = $signed({{PAD_C{1'b0}}, rect_bottom});
      cw = $signed({{PAD_L{1'b0}}, canvas_width});
      ch = $signed({{PAD_L{1'b0}}, canvas_height});
      // The rotation swaps the axes, so the y shift moves along memory rows.
      xs_raw = $signed({{PAD_S{shift_y[rbmrs_pkg::SHIFT_BITS-1]}}, shift_y});
      ys_raw = $signed({{PAD_S{shift_x[rbmrs_pkg::SHIFT_BITS-1]}}, shift_x});

      if (rotate_clockwise) begin
         rl = t;
         rr = b;
         rt = cw - r - ONE;
         rb = cw - l - ONE;
         xs = xs_raw;
         ys = -ys_raw;
      end else begin
         rl = ch - b - ONE;
         rr = ch - t - ONE;
         rt = l;
         rb = r;
         xs = -xs_raw;
         ys = ys_raw;
      end

      span_x = rr - rl + ONE;
      span_y = rb - rt + ONE;

      if (xs != ZERO) begin
         plan.dest_row = rt;
         plan.source_row = rt;
         height = span_y;
         walk_upward = 1'b0;
         if (xs > ZERO) begin
            dest_col = rl + xs;
            source_col = rl;
            width = span_x - xs;
         end else begin
            dest_col = rl;
            source_col = rl - xs;
            width = span_x + xs;
         end
      end else begin
         width = span_x;
         dest_col = rl;
         source_col = rl;
         if (ys > ZERO) begin
            // Downward move: walk from the bottom row up.
            plan.dest_row = rb;
            plan.source_row = rb - ys;
            height = span_y - ys;
            walk_upward = 1'b1;
         end else begin
            plan.dest_row = rt;
            plan.source_row = rt - ys;
            height = span_y + ys;
            walk_upward = 1'b0;
         end
      end

      pitch_ext = {{PAD_P{1'b0}}, row_pitch};
      dest_col_ext = {{PAD_O{dest_col[CB-1]}}, dest_col};
      source_col_ext = {{PAD_O{source_col[CB-1]}}, source_col};

      plan.opcode = opcode;
      plan.walk_upward = walk_upward;
      plan.empty = (width <= ZERO) || (height <= ZERO);
      plan.dest_col = dest_col_ext;
      plan.source_col = source_col_ext;
      plan.dest_col_next = walk_upward ? dest_col_ext - pitch_ext : dest_col_ext + pitch_ext;
      plan.source_col_next = walk_upward ? source_col_ext - pitch_ext
                                         : source_col_ext + pitch_ext;
      plan.copy_length = (width > RES_LIMIT) ? rbmrs_pkg::LEN_BITS'(rbmrs_pkg::MAX_RES)
                                             : width[rbmrs_pkg::LEN_BITS-1:0];
      plan.row_count = (height > RES_LIMIT) ? rbmrs_pkg::LEN_BITS'(rbmrs_pkg::MAX_RES)
                                            : height[rbmrs_pkg::LEN_BITS-1:0];
   end

endmodule

`default_nettype wire

@@ verif/tb_rotated_block_move_row_sequencer_unit.sv @@
`default_nettype none

module tb_rotated_block_move_row_sequencer_unit;

   localparam int OB = rbmrs_pkg::OFFSET_BITS;
   localparam int LB = rbmrs_pkg::LEN_BITS;
   localparam int KB = rbmrs_pkg::COORD_BITS;
   localparam int SB = rbmrs_pkg::SHIFT_BITS;
   localparam int IB = rbmrs_pkg::CSR_BITS;
   localparam int QUIET_LIMIT = 2000;

   typedef enum int {PACE_FULL, PACE_SLOW_SENDER, PACE_SLOW_RECEIVER, PACE_BOTH} pace_type;

   typedef struct packed {
      logic          row_valid;
      logic [OB-1:0] dest;
      logic [OB-1:0] source;
      logic [LB-1:0] length;
      logic          last;
   } row_cmd_type;

   typedef struct packed {
      logic                 opcode;
      logic [KB-1:0]        left;
      logic [KB-1:0]        top;
      logic [KB-1:0]        right;
      logic [KB-1:0]        bottom;
      logic signed [SB-1:0] shift_x;
      logic signed [SB-1:0] shift_y;
      logic                 hold_for_drain;
      row_cmd_type          due;
   } move_req_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write = 1'b0;
   logic [IB-1:0]        csr_index = rbmrs_pkg::CSR_ROTATE_CLOCKWISE;
   logic [LB-1:0]        csr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_opcode = rbmrs_pkg::OP_NEXT;
   logic [KB-1:0]        req_rect_left = '0;
   logic [KB-1:0]        req_rect_top = '0;
   logic [KB-1:0]        req_rect_right = '0;
   logic [KB-1:0]        req_rect_bottom = '0;
   logic signed [SB-1:0] req_shift_x = '0;
   logic signed [SB-1:0] req_shift_y = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_row_valid;
   logic [OB-1:0]        rsp_dest_offset;
   logic [OB-1:0]        rsp_source_offset;
   logic [LB-1:0]        rsp_row_length;
   logic                 rsp_last_row;

   rotated_block_move_row_sequencer_unit dut (
      .clock,
      .reset,
      .csr_write,
      .csr_index,
      .csr_data,
      .req_valid,
      .req_stall,
      .req_opcode,
      .req_rect_left,
      .req_rect_top,
      .req_rect_right,
      .req_rect_bottom,
      .req_shift_x,
      .req_shift_y,
      .rsp_valid,
      .rsp_stall,
      .rsp_row_valid,
      .rsp_dest_offset,
      .rsp_source_offset,
      .rsp_row_length,
      .rsp_last_row
   );

   // Register shadow and move state of the row sequencer, advanced in transaction order.
   logic          cfg_clockwise = 1'b1;
   logic [LB-1:0] cfg_canvas_w = 13'd320;
   logic [LB-1:0] cfg_canvas_h = 13'd240;
   logic [LB-1:0] cfg_pitch = 13'd240;
   logic          mv_busy = 1'b0;
   logic [LB-1:0] rows_to_go = '0;
   logic [OB-1:0] dest_ptr = '0;
   logic [OB-1:0] src_ptr = '0;
   logic [LB-1:0] run_length = '0;
   logic          walk_up = 1'b0;

   move_req_type move_reqs[$];
   row_cmd_type  row_cmds_due[$];
   int           items_made = 0;
   int           mismatches = 0;
   int           quiet_cycles = 0;
   bit           req_fired = 1'b0;
   pace_type     pace = PACE_FULL;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic row_cmd_type blank_cmd();
      row_cmd_type c;
      c.row_valid = 1'b0;
      c.dest = '0;
      c.source = '0;
      c.length = '0;
      c.last = 1'b1;
      return c;
   endfunction

   function automatic row_cmd_type issue_row();
      row_cmd_type   c;
      logic [OB-1:0] step;
      step = {{(OB - LB){1'b0}}, cfg_pitch};
      c.row_valid = 1'b1;
      c.dest = dest_ptr;
      c.source = src_ptr;
      c.length = run_length;
      rows_to_go = rows_to_go - 13'd1;
      c.last = (rows_to_go == '0);
      if (walk_up) begin
         dest_ptr = dest_ptr - step;
         src_ptr = src_ptr - step;
      end else begin
         dest_ptr = dest_ptr + step;
         src_ptr = src_ptr + step;
      end
      mv_busy = (rows_to_go != '0);
      return c;
   endfunction

   function automatic row_cmd_type next_row_command(move_req_type it);
      longint l, t, r, b, xs, ys, rl, rr, rt, rb, p, w, h, d0, s0;
      if (it.opcode == rbmrs_pkg::OP_NEXT)
         return mv_busy ? issue_row() : blank_cmd();
      l = longint'(it.left);
      t = longint'(it.top);
      r = longint'(it.right);
      b = longint'(it.bottom);
      // The rotation swaps the two axes.
      xs = longint'($signed(it.shift_y));
      ys = longint'($signed(it.shift_x));
      p = longint'(cfg_pitch);
      if (cfg_clockwise) begin
         rl = t;
         rr = b;
         rt = longint'(cfg_canvas_w) - r - 1;
         rb = longint'(cfg_canvas_w) - l - 1;
         ys = -ys;
      end else begin
         rl = longint'(cfg_canvas_h) - b - 1;
         rr = longint'(cfg_canvas_h) - t - 1;
         rt = l;
         rb = r;
         xs = -xs;
      end
      if (xs != 0) begin
         h = rb - rt + 1;
         walk_up = 1'b0;
         if (xs > 0) begin
            d0 = rt * p + rl + xs;
            s0 = rt * p + rl;
            w = rr - rl + 1 - xs;
         end else begin
            d0 = rt * p + rl;
            s0 = rt * p + rl - xs;
            w = rr - rl + 1 + xs;
         end
      end else begin
         w = rr - rl + 1;
         if (ys > 0) begin
            // Downward move: walk from the bottom row so that no source row is overwritten.
            d0 = rb * p + rl;
            s0 = (rb - ys) * p + rl;
            h = rb - rt + 1 - ys;
            walk_up = 1'b1;
         end else begin
            d0 = rt * p + rl;
            s0 = (rt - ys) * p + rl;
            h = rb - rt + 1 + ys;
            walk_up = 1'b0;
         end
      end
      if (w <= 0 || h <= 0) begin
         mv_busy = 1'b0;
         rows_to_go = '0;
         return blank_cmd();
      end
      if (w > rbmrs_pkg::MAX_RES) w = rbmrs_pkg::MAX_RES;
      if (h > rbmrs_pkg::MAX_RES) h = rbmrs_pkg::MAX_RES;
      run_length = w[LB-1:0];
      rows_to_go = h[LB-1:0];
      dest_ptr = d0[OB-1:0];
      src_ptr = s0[OB-1:0];
      mv_busy = 1'b1;
      return issue_row();
   endfunction

   function automatic move_req_type scramble_req();
      move_req_type it;
      int           s;
      it = '0;
      it.opcode = 1'($urandom_range(0, 1));
      it.left = KB'($urandom_range(0, 4095));
      it.top = KB'($urandom_range(0, 4095));
      it.right = KB'($urandom_range(0, 4095));
      it.bottom = KB'($urandom_range(0, 4095));
      s = int'($urandom_range(0, 8190)) - 4095;
      it.shift_x = s[SB-1:0];
      s = int'($urandom_range(0, 8190)) - 4095;
      it.shift_y = s[SB-1:0];
      return it;
   endfunction

   function automatic logic signed [SB-1:0] rand_shift();
      int m;
      m = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 4095))
                                      : int'($urandom_range(0, 12));
      if ($urandom_range(0, 1) != 0) m = -m;
      return m[SB-1:0];
   endfunction

   task automatic post_req(move_req_type it);
      it.hold_for_drain = ((items_made % 64) == 10);
      it.due = next_row_command(it);
      move_reqs.push_back(it);
      items_made++;
   endtask

   task automatic post_start(int l, int t, int r, int b,
                             logic signed [SB-1:0] sx,
                             logic signed [SB-1:0] sy);
      move_req_type it;
      it = '0;
      it.opcode = rbmrs_pkg::OP_START;
      it.left = l[KB-1:0];
      it.top = t[KB-1:0];
      it.right = r[KB-1:0];
      it.bottom = b[KB-1:0];
      it.shift_x = sx;
      it.shift_y = sy;
      post_req(it);
   endtask

   task automatic post_next(int n);
      move_req_type it;
      for (int i = 0; i < n; i++) begin
         // The rectangle and shift fields of a next are don't-cares, so they carry noise.
         it = scramble_req();
         it.opcode = rbmrs_pkg::OP_NEXT;
         post_req(it);
      end
   endtask

   task automatic random_move();
      int span_w, span_h, l, t, r, b, kind, rows, nexts;
      logic signed [SB-1:0] sx, sy;
      kind = int'($urandom_range(0, 9));
      if (kind == 0) begin
         post_req(scramble_req());
         return;
      end
      span_w = (cfg_canvas_w == '0) ? 1
             : ((int'(cfg_canvas_w) > 4096) ? 4096 : int'(cfg_canvas_w));
      span_h = (cfg_canvas_h == '0) ? 1
             : ((int'(cfg_canvas_h) > 4096) ? 4096 : int'(cfg_canvas_h));
      l = int'($urandom_range(0, span_w - 1));
      t = int'($urandom_range(0, span_h - 1));
      r = l + (($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 4095))
                                           : int'($urandom_range(0, 23)));
      b = t + (($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 4095))
                                           : int'($urandom_range(0, 23)));
      if (r > 4095) r = 4095;
      if (b > 4095) b = 4095;
      sx = rand_shift();
      sy = rand_shift();
      case ($urandom_range(0, 3))
         0: sy = '0;
         1: sx = '0;
         2: ;
         default: begin
            sx = '0;
            sy = '0;
         end
      endcase
      post_start(l, t, r, b, sx, sy);
      rows = mv_busy ? int'(rows_to_go) : 0;
      // A broken sequence may stop early and leave the move to be abandoned by the next start.
      nexts = (kind == 1) ? int'($urandom_range(0, rows)) : rows + int'($urandom_range(0, 2));
      if (nexts > 40) nexts = 40;
      post_next(nexts);
   endtask

   task automatic settle_block();
      // An empty start clears any move in progress before the registers change.
      if (mv_busy) post_start(0, 5, 0, 0, '0, '0);
      while (move_reqs.size() != 0 || row_cmds_due.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [IB-1:0] idx, logic [LB-1:0] val);
      case (idx)
         rbmrs_pkg::CSR_ROTATE_CLOCKWISE: cfg_clockwise = val[0];
         rbmrs_pkg::CSR_CANVAS_WIDTH:     cfg_canvas_w = val;
         rbmrs_pkg::CSR_CANVAS_HEIGHT:    cfg_canvas_h = val;
         rbmrs_pkg::CSR_ROW_PITCH:        cfg_pitch = val;
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic run_phase(logic cw, int w, int h, int pitch, pace_type mode, int count);
      int target;
      settle_block();
      write_csr(rbmrs_pkg::CSR_ROTATE_CLOCKWISE, {12'd0, cw});
      write_csr(rbmrs_pkg::CSR_CANVAS_WIDTH, w[LB-1:0]);
      write_csr(rbmrs_pkg::CSR_CANVAS_HEIGHT, h[LB-1:0]);
      write_csr(rbmrs_pkg::CSR_ROW_PITCH, pitch[LB-1:0]);
      pace = mode;
      target = items_made + count;
      while (items_made < target) random_move();
   endtask

   // Driver: a stalled transaction is held until it is taken.
   always @(negedge clock) begin : drive_req
      bit gap;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         req_fired = 1'b0;
         gap = (pace == PACE_SLOW_SENDER && $urandom_range(0, 99) < 81) ||
               (pace == PACE_BOTH && $urandom_range(0, 99) < 10);
         if (move_reqs.size() != 0 && !gap &&
             !(move_reqs[0].hold_for_drain && row_cmds_due.size() != 0)) begin
            req_valid <= 1'b1;
            req_opcode <= move_reqs[0].opcode;
            req_rect_left <= move_reqs[0].left;
            req_rect_top <= move_reqs[0].top;
            req_rect_right <= move_reqs[0].right;
            req_rect_bottom <= move_reqs[0].bottom;
            req_shift_x <= move_reqs[0].shift_x;
            req_shift_y <= move_reqs[0].shift_y;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= (pace == PACE_SLOW_RECEIVER && $urandom_range(0, 99) < 81) ||
                   (pace == PACE_BOTH && $urandom_range(0, 99) < 10);
   end

   // Monitor: results are checked before this edge's accepted request is queued.
   always @(posedge clock) begin : watch_rows
      row_cmd_type want;
      bit          moved;
      moved = 1'b0;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (row_cmds_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected row command: row_valid=%0d dest=%h source=%h %s",
                           rsp_row_valid, rsp_dest_offset, rsp_source_offset,
                           $sformatf("len=%0d last=%0d", rsp_row_length, rsp_last_row));
            end else begin
               want = row_cmds_due.pop_front();
               if (rsp_row_valid !== want.row_valid || rsp_dest_offset !== want.dest ||
                   rsp_source_offset !== want.source || rsp_row_length !== want.length ||
                   rsp_last_row !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("row command mismatch at %0t", $realtime);
                     $display("  expected row_valid=%0d dest=%h source=%h len=%0d last=%0d",
                              want.row_valid, want.dest, want.source, want.length, want.last);
                     $display("  actual   row_valid=%0d dest=%h source=%h len=%0d last=%0d",
                              rsp_row_valid, rsp_dest_offset, rsp_source_offset,
                              rsp_row_length, rsp_last_row);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            row_cmds_due.push_back(move_reqs[0].due);
            void'(move_reqs.pop_front());
            req_fired = 1'b1;
         end
         if (moved || (move_reqs.size() == 0 && row_cmds_due.size() == 0))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(negedge clock);
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset settings: clockwise, 320 by 240, pitch 240.
      post_next(1);
      post_start(10, 20, 40, 60, 5, 0);
      post_next(3);
      post_start(10, 20, 40, 60, -5, 0);
      post_next(2);
      post_start(10, 20, 40, 60, 0, 7);
      post_next(2);
      post_start(10, 20, 40, 60, 0, -7);
      post_next(1);
      // Starts while the previous move is still running, then runs past its last row.
      post_start(0, 0, 3, 2, 0, 1);
      post_next(4);
      post_start(10, 20, 12, 22, 0, 100);
      post_start(10, 20, 12, 22, 50, 0);
      // Full-size rectangles: a row count of 4096 and offsets that wrap.
      post_start(0, 0, 4095, 4095, 4095, 0);
      post_next(1);
      post_start(4095, 4095, 4095, 4095, -4095, -4095);
      post_next(1);
      post_start(0, 0, 4095, 4095, 0, -4095);

      run_phase(1'b1, 320, 240, 240, PACE_SLOW_SENDER, 170);
      run_phase(1'b0, 240, 320, 320, PACE_SLOW_RECEIVER, 170);
      run_phase(1'b1, 1, 1, 1, PACE_BOTH, 120);
      run_phase(1'b0, 4096, 4096, 4096, PACE_FULL, 170);
      run_phase(1'b1, 8191, 8191, 8191, PACE_SLOW_RECEIVER, 100);
      run_phase(1'b0, 0, 0, 0, PACE_SLOW_SENDER, 60);
      run_phase(1'($urandom_range(0, 1)), int'($urandom_range(1, 4096)),
                int'($urandom_range(1, 4096)), int'($urandom_range(1, 4096)), PACE_BOTH, 170);
      run_phase(1'b1, 640, 480, 480, PACE_FULL, 150);
      run_phase(1'b0, 17, 4095, 33, PACE_SLOW_SENDER, 100);

      settle_block();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && row_cmds_due.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire

@@ rotated_block_move_row_sequencer_unit.f @@
+incdir+hw/rtl
hw/rtl/rbmrs_pkg.sv
hw/rtl/rbmrs_geom.sv
hw/rtl/rotated_block_move_row_sequencer_unit.sv
verif/tb_rotated_block_move_row_sequencer_unit.sv
